[hdl/bgrx_to_yuv420_macros.svh]
// ----------------------------------------------------------------------------
// bgrx_to_yuv420 assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BGRX_TO_YUV420_MACROS_SVH
`define BGRX_TO_YUV420_MACROS_SVH

// same-cycle implication
`define B2Y_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2Y_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/b2y_pkg.sv]
// ----------------------------------------------------------------------------
// b2y_pkg
// types, constants and helpers of the bgrx to yuv420 converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2y_pkg;

  localparam int MaxWidth     = 2048;
  localparam int MaxHeight    = 4096;
  localparam int GroupPixels  = 16;
  localparam int MaxGroups    = MaxWidth / GroupPixels;
  localparam int GroupShift   = $clog2(GroupPixels);
  localparam int ColW         = $clog2(MaxWidth);
  localparam int RowW         = $clog2(MaxHeight);
  localparam int WidthW       = ColW + 1;
  localparam int HeightW      = RowW + 1;

  localparam int CfgGroupsW   = 8;
  localparam int CfgRowsW     = 13;
  localparam int CfgDataW     = 13;
  localparam int GroupsReset  = 120;
  localparam int RowsReset    = 1080;

  // luma coefficients and shift
  localparam int LumaB        = 9;
  localparam int LumaG        = 92;
  localparam int LumaR        = 27;
  localparam int LumaShift    = 7;
  localparam int LumaSumW     = 15;

  // chroma coefficient magnitudes, signs are in the datapath
  localparam int CoefUB       = 64;
  localparam int CoefUG       = 49;
  localparam int CoefUR       = 15;
  localparam int CoefVB       = 6;
  localparam int CoefVG       = 58;
  localparam int CoefVR       = 64;
  localparam int ChromaShift  = 7;
  localparam int ChromaBias   = 128;
  localparam int ChromaSumW   = 16;

  typedef enum logic [0:0] {
    RegWidthGroups = 1'b0,
    RegHeightRows  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] u_out;
    logic [7:0] v_out;
    logic       frame_end;
  } pix_out_t;

  // beat handed from the averaging stage to the color stage
  typedef struct packed {
    logic       vld;
    logic [7:0] luma;
    logic       chroma;
    pix_in_t    avg;
    logic       fend;
  } cs_beat_t;

  function automatic logic [7:0] avg_byte(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b) + 9'd1;
    return s[8:1];
  endfunction

  function automatic pix_in_t avg_pix(pix_in_t a, pix_in_t b);
    pix_in_t r;
    r.blue  = avg_byte(a.blue, b.blue);
    r.green = avg_byte(a.green, b.green);
    r.red   = avg_byte(a.red, b.red);
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/b2y_csc.sv]
// ----------------------------------------------------------------------------
// b2y_csc
// color stage: luma pass-through, chroma matrix, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bgrx_to_yuv420_macros.svh"

module b2y_csc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire b2y_pkg::cs_beat_t beat_i,
  output logic                   out_valid_o,
  output b2y_pkg::pix_out_t      out_data_o
);
  import b2y_pkg::*;

  logic [ChromaSumW-1:0] sum_u, sum_v;
  logic [7:0]            u_d, v_d;
  logic                  out_valid_q;
  pix_out_t              out_q;

  always_comb begin
    sum_u = ChromaSumW'(CoefUB) * ChromaSumW'(beat_i.avg.blue)
          - ChromaSumW'(CoefUG) * ChromaSumW'(beat_i.avg.green)
          - ChromaSumW'(CoefUR) * ChromaSumW'(beat_i.avg.red);
    sum_v = ChromaSumW'(CoefVR) * ChromaSumW'(beat_i.avg.red)
          - ChromaSumW'(CoefVG) * ChromaSumW'(beat_i.avg.green)
          - ChromaSumW'(CoefVB) * ChromaSumW'(beat_i.avg.blue);
    u_d = beat_i.chroma ? sum_u[ChromaShift+7:ChromaShift] + 8'(ChromaBias) : '0;
    v_d = beat_i.chroma ? sum_v[ChromaShift+7:ChromaShift] + 8'(ChromaBias) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.luma         <= beat_i.luma;
      out_q.chroma_valid <= beat_i.chroma;
      out_q.u_out        <= u_d;
      out_q.v_out        <= v_d;
      out_q.frame_end    <= beat_i.fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `B2Y_ASSERT_IMPL(a_uv_zero_idle, out_valid_o && !out_data_o.chroma_valid, out_data_o.u_out == '0 && out_data_o.v_out == '0, "chroma nonzero without chroma_valid")
  `B2Y_ASSERT_NEXT(a_out_load, en_i && beat_i.vld, out_valid_o, "color stage lost a beat")
  `B2Y_ASSERT_NEXT(a_out_hold, out_valid_o && !en_i, out_valid_o && $stable(out_data_o), "output beat changed while stalled")

endmodule

`default_nettype wire

[hdl/bgrx_to_yuv420.sv]
// ----------------------------------------------------------------------------
// bgrx_to_yuv420
// streaming bgrx to yuv 4:2:0 converter with a one-row line store
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready) in raster order, one beat per
// pixel; every input beat yields exactly one output beat with the pixel's
// luma and, on the odd column of each 2x2 block's odd row or of an even last
// row, its U and V. frame_end marks the last pixel of the frame. Frame size
// comes from the two registers of the write port (width in groups of 16
// pixels, height in rows). Throughput is one pixel per cycle unless the
// receiver stalls; the line store (one write port, one read port) is
// written in even rows and read per pixel, the data used in odd rows. Beats
// pass the line store read, averaging, color matrix into the output register.
// Reset clears the row and column counters, the pipeline valids and loads the
// register defaults (1920 x 1080); the line store is not cleared and needs
// no clearing pass. When the receiver stalls the whole pipeline holds and
// in_ready_o drops; a new beat is still taken while the output register
// holds a result, as long as out_ready_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bgrx_to_yuv420_macros.svh"

module bgrx_to_yuv420 (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire b2y_pkg::reg_idx_e               cfg_idx_i,
  input  wire logic [b2y_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire b2y_pkg::pix_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output b2y_pkg::pix_out_t                    out_data_o
);
  import b2y_pkg::*;

  logic [CfgGroupsW-1:0] groups_q;
  logic [CfgRowsW-1:0]   rows_q;
  logic [WidthW-1:0]     width_pix;
  logic [HeightW-1:0]    height_eff;
  logic [CfgGroupsW-1:0] groups_eff;

  logic [ColW-1:0]       col_q;
  logic [RowW-1:0]       row_q;
  logic                  en, acc, odd_row, last_row, row_end;

  pix_in_t               line_mem [MaxWidth];
  pix_in_t               rd_q;

  logic                  s1_vld_q, s1_odd_q, s1_crow_q, s1_codd_q, s1_fend_q;
  pix_in_t               s1_pix_q;
  pix_in_t               vavg;
  pix_in_t               held_q;
  logic [LumaSumW-1:0]   luma_sum;
  cs_beat_t              s2_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= CfgGroupsW'(GroupsReset);
      rows_q   <= CfgRowsW'(RowsReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidthGroups: groups_q <= cfg_data_i[CfgGroupsW-1:0];
        RegHeightRows:  rows_q   <= cfg_data_i[CfgRowsW-1:0];
        default:        groups_q <= groups_q;
      endcase
    end
  end

  always_comb begin
    priority if (groups_q == '0) begin
      groups_eff = CfgGroupsW'(1);
    end else if (32'(groups_q) > MaxGroups) begin
      groups_eff = CfgGroupsW'(MaxGroups);
    end else begin
      groups_eff = groups_q;
    end
    width_pix = WidthW'(groups_eff) << GroupShift;
    priority if (rows_q == '0) begin
      height_eff = HeightW'(1);
    end else if (32'(rows_q) > MaxHeight) begin
      height_eff = HeightW'(MaxHeight);
    end else begin
      height_eff = HeightW'(rows_q);
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && in_ready_o;
  assign odd_row    = row_q[0];
  assign last_row   = (HeightW'(row_q) + HeightW'(1)) >= height_eff;
  assign row_end    = (WidthW'(col_q) + WidthW'(1)) >= width_pix;

  // raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // line store: even rows write, odd rows use the read data
  always_ff @(posedge clk_i) begin
    if (acc && !odd_row) begin
      line_mem[col_q] <= in_data_i;
    end
    if (en) begin
      rd_q <= line_mem[col_q];
    end
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pix_q  <= in_data_i;
      s1_odd_q  <= odd_row;
      s1_crow_q <= odd_row || last_row;
      s1_codd_q <= col_q[0];
      s1_fend_q <= row_end && last_row;
    end
  end

  always_comb begin
    vavg     = s1_odd_q ? avg_pix(rd_q, s1_pix_q) : s1_pix_q;
    luma_sum = LumaSumW'(LumaR) * LumaSumW'(s1_pix_q.red)
             + LumaSumW'(LumaG) * LumaSumW'(s1_pix_q.green)
             + LumaSumW'(LumaB) * LumaSumW'(s1_pix_q.blue);
  end

  // even-column vertical average
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (en && s1_vld_q && s1_crow_q && !s1_codd_q) begin
      held_q <= vavg;
    end
  end

  // stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q.vld    <= s1_vld_q;
      s2_q.luma   <= luma_sum[LumaShift+7:LumaShift];
      s2_q.chroma <= s1_crow_q && s1_codd_q;
      s2_q.avg    <= avg_pix(held_q, vavg);
      s2_q.fend   <= s1_fend_q;
    end
  end

  b2y_csc u_csc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .beat_i      (s2_q),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `B2Y_ASSERT_NEXT(a_acc_enters, acc, s1_vld_q, "accepted beat missing from stage 1")
  `B2Y_ASSERT_NEXT(a_frame_wrap, acc && row_end && last_row, col_q == '0 && row_q == '0, "counters did not wrap at frame end")
  `B2Y_ASSERT_NEXT(a_stall_keeps, s2_q.vld && !en, s2_q.vld, "stage 2 beat dropped while stalled")

endmodule

`default_nettype wire
